// File: sv/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted insertion priority queue:
// command codes, cell operations and the words passed between cells.
// ----------------------------------------------------------------------------
package sipq_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CMD_W  = 2;

	// Commands carried on the request channel
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_PUSH   = 2'd1,
		CELL_POP    = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// Broadcast control: operation and the value it compares against
	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

	// Content of one cell
	typedef struct packed {
		logic                      valid;
		logic signed [DATA_W-1:0]  data;
	} cell_slot_t;

	// What a cell hands to its right-hand neighbor
	typedef struct packed {
		logic       ins;
		cell_slot_t slot;
	} cell_link_t;

endpackage

// File: sv/sipq_in_if.sv
// ----------------------------------------------------------------------------
// sipq_in_if
// Request channel: valid/ready handshake with a command word and its value.
// ----------------------------------------------------------------------------
interface sipq_in_if;

	logic                              valid;
	logic                              ready;
	logic [sipq_pkg::CMD_W-1:0]        cmd;
	logic signed [sipq_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);

endinterface

// File: sv/sipq_out_if.sv
// ----------------------------------------------------------------------------
// sipq_out_if
// Response channel: valid/ready handshake with one status word per command.
// ----------------------------------------------------------------------------
interface sipq_out_if #(
	parameter int unsigned CNT_W = 5
);

	logic                               valid;
	logic                               ready;
	logic signed [sipq_pkg::DATA_W-1:0] front_value;
	logic                               is_empty;
	logic [CNT_W-1:0]                   entries_held;
	logic                               dropped;

	modport source (output valid, output front_value, output is_empty,
		output entries_held, output dropped, input ready);
	modport sink   (input valid, input front_value, input is_empty,
		input entries_held, input dropped, output ready);

endinterface

// File: sv/sorted_insert_priority_queue.sv
// Sorted insertion priority queue: keeps up to DEPTH signed 32-bit values in
// ascending order in a row of cells and returns one status word per command
// (smallest value, empty flag, occupancy, drop flag). Push, pop and read need
// no busy state, so they can be issued back to back while the response slot
// is free. Remove holds off requests in a busy state: the cell row closes one
// gap per cycle, one per stored copy of the value, and the status word follows
// once no copy is left and the slot is free. A push into a full queue leaves
// the store unchanged and sets the drop flag. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Top level: command sequencer, occupancy counter, response register and the
// chain of storage cells.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sipq_in_if.sink     req,
	sipq_out_if.source  rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_REMOVE = 2'b10
	} state_t;

	state_t                              state_q;
	state_t                              state_d;
	logic signed [sipq_pkg::DATA_W-1:0]  value_q;
	logic [CNT_W-1:0]                    occ_q;
	logic [CNT_W-1:0]                    occ_d;
	logic                                drop_d;
	logic                                load_res;
	logic                                res_free;
	logic                                req_fire;
	logic                                full;
	logic                                any_eq;

	logic                                rsp_valid_q;
	logic signed [sipq_pkg::DATA_W-1:0]  front_q;
	logic                                empty_q;
	logic [CNT_W-1:0]                    held_q;
	logic                                dropped_q;

	sipq_pkg::cell_ctrl_t                ctrl;
	sipq_pkg::cell_link_t                link [DEPTH];
	sipq_pkg::cell_slot_t                nxt  [DEPTH];
	logic [DEPTH-1:0]                    eq;

	// Handshake
	assign res_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && res_free;
	assign req_fire  = req.valid && req.ready;
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign any_eq    = |eq;

	// Sequence commands and drive the cell row
	always_comb begin
		ctrl.value = (state_q == ST_IDLE) ? req.value : value_q;
		ctrl.op    = sipq_pkg::CELL_HOLD;
		occ_d      = occ_q;
		drop_d     = 1'b0;
		load_res   = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					unique case (sipq_pkg::cmd_t'(req.cmd))
						sipq_pkg::CMD_PUSH: begin
							if (full) begin
								drop_d = 1'b1;
							end else begin
								ctrl.op = sipq_pkg::CELL_PUSH;
								occ_d   = occ_q + CNT_W'(1);
							end
							load_res = 1'b1;
						end
						sipq_pkg::CMD_POP: begin
							if (occ_q != '0) begin
								ctrl.op = sipq_pkg::CELL_POP;
								occ_d   = occ_q - CNT_W'(1);
							end
							load_res = 1'b1;
						end
						sipq_pkg::CMD_REMOVE: begin
							state_d = ST_REMOVE;
						end
						sipq_pkg::CMD_READ: begin
							load_res = 1'b1;
						end
						default: begin
							load_res = 1'b1;
						end
					endcase
				end
			end
			ST_REMOVE: begin
				if (any_eq) begin
					ctrl.op = sipq_pkg::CELL_REMOVE;
					occ_d   = occ_q - CNT_W'(1);
				end else if (res_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (load_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture remove value and response word
	always_ff @(posedge clk) begin
		if (req_fire) begin
			value_q <= req.value;
		end
		if (load_res) begin
			front_q   <= nxt[0].valid ? nxt[0].data : '0;
			empty_q   <= (occ_d == '0);
			held_q    <= occ_d;
			dropped_q <= drop_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.front_value  = front_q;
	assign rsp.is_empty     = empty_q;
	assign rsp.entries_held = held_q;
	assign rsp.dropped      = dropped_q;

	// Row of cells, smallest value in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sipq_pkg::cell_link_t left_in;
		sipq_pkg::cell_slot_t right_in;

		if (i == 0) begin : g_first
			assign left_in = '{ins: 1'b0, slot: '0};
		end else begin : g_mid
			assign left_in = link[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = link[i+1].slot;
		end

		sipq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_in),
			.right  (right_in),
			.link   (link[i]),
			.nxt    (nxt[i]),
			.eq     (eq[i])
		);
	end

endmodule

// File: sv/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell
// One storage cell of the sorted row. Compares its entry with the broadcast
// value and takes its own, its left neighbor's, its right neighbor's or the
// new value according to the broadcast operation.
// ----------------------------------------------------------------------------
module sipq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sipq_pkg::cell_ctrl_t  ctrl,
	input  sipq_pkg::cell_link_t  left,
	input  sipq_pkg::cell_slot_t  right,
	output sipq_pkg::cell_link_t  link,
	output sipq_pkg::cell_slot_t  nxt,
	output logic                  eq
);

	sipq_pkg::cell_slot_t slot_q;
	logic                 gt;
	logic                 ge;
	logic                 ins;

	// Compare stored entry with the broadcast value
	assign gt  = slot_q.valid && ($signed(slot_q.data) >  $signed(ctrl.value));
	assign ge  = slot_q.valid && ($signed(slot_q.data) >= $signed(ctrl.value));
	assign eq  = slot_q.valid && (slot_q.data == ctrl.value);
	// New value lands at or before this cell
	assign ins = !slot_q.valid || gt;

	assign link = '{ins: ins, slot: slot_q};

	// Select next content
	always_comb begin
		nxt = slot_q;
		unique case (ctrl.op)
			sipq_pkg::CELL_HOLD: begin
				nxt = slot_q;
			end
			sipq_pkg::CELL_PUSH: begin
				if (ins) begin
					if (left.ins) begin
						nxt = left.slot;
					end else begin
						nxt = '{valid: 1'b1, data: ctrl.value};
					end
				end
			end
			sipq_pkg::CELL_POP: begin
				nxt = right;
			end
			sipq_pkg::CELL_REMOVE: begin
				if (!slot_q.valid || ge) begin
					nxt = right;
				end
			end
			default: begin
				nxt = slot_q;
			end
		endcase
	end

	// Hold entry; only the valid flag is cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.valid <= 1'b0;
		end else begin
			slot_q <= nxt;
		end
	end

endmodule
